// ===== design/esu_pkg.sv =====
// ----------------------------------------------------------------------------
// esu_pkg
// Shared types, codes and constants of the ESC arming safety supervisor.
// ----------------------------------------------------------------------------
package esu_pkg;

  // Field widths
  localparam int unsigned PULSE_W = 15;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Timeouts
  localparam int unsigned ARM_CONFIRM_TIMEOUT_MS  = 5000;
  localparam int unsigned STARTUP_HALL_TIMEOUT_MS = 2000;
  localparam int unsigned RUNNING_HALL_TIMEOUT_US = 500000;

  // Duty scaling: duty = pulse * (2^DUTY_BITS - 1) / PWM_PERIOD_US
  localparam int unsigned DUTY_BITS     = 16;
  localparam int unsigned PWM_PERIOD_US = 20000;
  localparam int unsigned RECIP_SHIFT   = 16;
  localparam int unsigned DUTY_QW       = DUTY_BITS + 1;
  localparam int unsigned DUTY_RECIP_W  = DUTY_BITS + 2;
  localparam int unsigned DUTY_NUM_W    = DUTY_BITS + 16;
  localparam logic [63:0] DUTY_FULL     = (64'd1 << DUTY_BITS) - 64'd1;
  localparam logic [63:0] DUTY_RECIP    = (DUTY_FULL << RECIP_SHIFT) / 64'd20000;

  // Reset values
  localparam logic [PULSE_W-1:0] SAFE_PULSE_RST   = 15'd1000;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST    = 15'd2000;
  localparam logic [MS_W-1:0]    HB_TIMEOUT_RST   = 16'd500;
  localparam logic [RPM_W-1:0]   RPM_LIMIT_RST    = 16'd3000;
  localparam logic [PULSE_W-1:0] HALL_REQ_RST     = 15'd1100;
  localparam logic [PULSE_W-1:0] RAMP_STEP_RST    = 15'd5;
  localparam logic [MS_W-1:0]    RAMP_PERIOD_RST  = 16'd20;
  localparam logic [PULSE_W-1:0] PULSE_RST        = 15'd1000;

  typedef enum logic [2:0] {
    ACT_START     = 3'd0,
    ACT_REQ_ARM   = 3'd1,
    ACT_CONFIRM   = 3'd2,
    ACT_THROTTLE  = 3'd3,
    ACT_KEEPALIVE = 3'd4,
    ACT_STOP      = 3'd5,
    ACT_CLEAR     = 3'd6,
    ACT_TICK      = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    MODE_LOCKED   = 3'd0,
    MODE_DISARMED = 3'd1,
    MODE_PENDING  = 3'd2,
    MODE_ARMED    = 3'd3,
    MODE_RUNNING  = 3'd4,
    MODE_FAULT    = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    FAULT_NONE      = 3'd0,
    FAULT_HEARTBEAT = 3'd1,
    FAULT_OVERSPEED = 3'd2,
    FAULT_NOHALL    = 3'd3,
    FAULT_HALLLOST  = 3'd4
  } fault_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_EN   = 3'd0,
    CFG_SAFE_PULSE  = 3'd1,
    CFG_MAX_PULSE   = 3'd2,
    CFG_HB_TIMEOUT  = 3'd3,
    CFG_RPM_LIMIT   = 3'd4,
    CFG_HALL_REQ    = 3'd5,
    CFG_RAMP_STEP   = 3'd6,
    CFG_RAMP_PERIOD = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic               active_enable;
    logic [PULSE_W-1:0] safe_pulse_us;
    logic [PULSE_W-1:0] max_pulse_us;
    logic [MS_W-1:0]    heartbeat_timeout_ms;
    logic [RPM_W-1:0]   hard_rpm_limit;
    logic [PULSE_W-1:0] hall_required_us;
    logic [PULSE_W-1:0] ramp_step_us;
    logic [MS_W-1:0]    ramp_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  now_us;
    logic [TIME_W-1:0]  hall_last_us;
    logic [RPM_W-1:0]   motor_rpm;
    logic [PULSE_W-1:0] pulse_us;
  } in_item_t;

  // Step result before the duty count is attached
  typedef struct packed {
    logic               accepted;
    logic [2:0]         mode_now;
    logic [PULSE_W-1:0] requested_pulse_us;
    logic [PULSE_W-1:0] actual_pulse_us;
    logic [2:0]         fault_code_out;
    logic               active_allowed;
    logic               pulse_written;
  } step_res_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         mode_now;
    logic [PULSE_W-1:0] requested_pulse_us;
    logic [PULSE_W-1:0] actual_pulse_us;
    logic [2:0]         fault_code_out;
    logic [DUTY_W-1:0]  pwm_duty;
    logic               active_allowed;
    logic               pulse_written;
  } out_item_t;

endpackage

// ===== design/esu_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// esu_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module esu_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [esu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [esu_pkg::CFG_W-1:0]      cfg_data_i,
  output esu_pkg::cfg_t                  cfg_o
);

  esu_pkg::cfg_t cfg_q;

  // Register writes, truncated to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_enable        <= 1'b0;
      cfg_q.safe_pulse_us        <= esu_pkg::SAFE_PULSE_RST;
      cfg_q.max_pulse_us         <= esu_pkg::MAX_PULSE_RST;
      cfg_q.heartbeat_timeout_ms <= esu_pkg::HB_TIMEOUT_RST;
      cfg_q.hard_rpm_limit       <= esu_pkg::RPM_LIMIT_RST;
      cfg_q.hall_required_us     <= esu_pkg::HALL_REQ_RST;
      cfg_q.ramp_step_us         <= esu_pkg::RAMP_STEP_RST;
      cfg_q.ramp_period_ms       <= esu_pkg::RAMP_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (esu_pkg::cfg_idx_e'(cfg_idx_i))
        esu_pkg::CFG_ACTIVE_EN:   cfg_q.active_enable        <= cfg_data_i[0];
        esu_pkg::CFG_SAFE_PULSE:  cfg_q.safe_pulse_us        <= cfg_data_i[14:0];
        esu_pkg::CFG_MAX_PULSE:   cfg_q.max_pulse_us         <= cfg_data_i[14:0];
        esu_pkg::CFG_HB_TIMEOUT:  cfg_q.heartbeat_timeout_ms <= cfg_data_i;
        esu_pkg::CFG_RPM_LIMIT:   cfg_q.hard_rpm_limit       <= cfg_data_i;
        esu_pkg::CFG_HALL_REQ:    cfg_q.hall_required_us     <= cfg_data_i[14:0];
        esu_pkg::CFG_RAMP_STEP:   cfg_q.ramp_step_us         <= cfg_data_i[14:0];
        esu_pkg::CFG_RAMP_PERIOD: cfg_q.ramp_period_ms       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/esu_step.sv =====
// ----------------------------------------------------------------------------
// esu_step
// Supervisor state and the per-item command/tick logic.
// ----------------------------------------------------------------------------
module esu_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  esu_pkg::cfg_t       cfg_i,
  input  esu_pkg::in_item_t   item_i,
  input  logic                advance_i,
  output esu_pkg::step_res_t  res_o
);

  localparam int unsigned PW = esu_pkg::PULSE_W;
  localparam int unsigned TW = esu_pkg::TIME_W;

  esu_pkg::mode_e  mode_q, mode_d;
  esu_pkg::fault_e fault_q, fault_d;
  logic [PW-1:0]   target_q, target_d;
  logic [PW-1:0]   output_q, output_d;
  logic [TW-1:0]   arm_time_q, arm_time_d;
  logic [TW-1:0]   hb_time_q, hb_time_d;
  logic [TW-1:0]   run_time_q, run_time_d;
  logic [TW-1:0]   ramp_time_q, ramp_time_d;

  logic            ok, written, stop, pend, trip;
  esu_pkg::fault_e trip_code;
  logic            armed_or_run, running, hall_check;
  logic            arm_late, hb_late, over_rpm, start_late, hall_late, ramp_wait;
  logic [TW-1:0]   arm_el, hb_el, run_el, ramp_el, hall_el;
  logic [PW:0]     ramp_up;
  logic [PW-1:0]   ramp_gap, ramp_val;

  // Elapsed times, all modulo 2^32
  always_comb begin
    arm_el  = item_i.now_ms - arm_time_q;
    hb_el   = item_i.now_ms - hb_time_q;
    run_el  = item_i.now_ms - run_time_q;
    ramp_el = item_i.now_ms - ramp_time_q;
    hall_el = item_i.now_us - item_i.hall_last_us;
  end

  assign armed_or_run = (mode_q == esu_pkg::MODE_ARMED) || (mode_q == esu_pkg::MODE_RUNNING);
  assign running      = (mode_q == esu_pkg::MODE_RUNNING);
  assign hall_check   = running && (target_q >= cfg_i.hall_required_us);
  assign arm_late     = arm_el > TW'(esu_pkg::ARM_CONFIRM_TIMEOUT_MS);
  assign hb_late      = hb_el > TW'(cfg_i.heartbeat_timeout_ms);
  assign over_rpm     = item_i.motor_rpm > cfg_i.hard_rpm_limit;
  assign start_late   = run_el > TW'(esu_pkg::STARTUP_HALL_TIMEOUT_MS);
  assign hall_late    = hall_el > TW'(esu_pkg::RUNNING_HALL_TIMEOUT_US);
  assign ramp_wait    = ramp_el < TW'(cfg_i.ramp_period_ms);

  // Ramp one step toward the target
  always_comb begin
    ramp_up  = {1'b0, output_q} + {1'b0, cfg_i.ramp_step_us};
    ramp_gap = output_q - target_q;
    if (output_q < target_q) begin
      ramp_val = (ramp_up < {1'b0, target_q}) ? ramp_up[PW-1:0] : target_q;
    end else if (output_q > target_q) begin
      ramp_val = (ramp_gap > cfg_i.ramp_step_us) ? (output_q - cfg_i.ramp_step_us)
                                                  : target_q;
    end else begin
      ramp_val = output_q;
    end
  end

  // Command decode and next state
  always_comb begin
    mode_d      = mode_q;
    fault_d     = fault_q;
    target_d    = target_q;
    output_d    = output_q;
    arm_time_d  = arm_time_q;
    hb_time_d   = hb_time_q;
    run_time_d  = run_time_q;
    ramp_time_d = ramp_time_q;
    ok          = 1'b1;
    written     = 1'b0;
    stop        = 1'b0;
    pend        = 1'b0;
    trip        = 1'b0;
    trip_code   = esu_pkg::FAULT_NONE;

    case (esu_pkg::action_e'(item_i.action))
      esu_pkg::ACT_START, esu_pkg::ACT_STOP: begin
        stop = 1'b1;
      end
      esu_pkg::ACT_REQ_ARM: begin
        if (!cfg_i.active_enable || mode_q == esu_pkg::MODE_FAULT) begin
          ok = 1'b0;
        end else begin
          stop       = 1'b1;
          pend       = 1'b1;
          arm_time_d = item_i.now_ms;
          hb_time_d  = item_i.now_ms;
        end
      end
      esu_pkg::ACT_CONFIRM: begin
        if (mode_q != esu_pkg::MODE_PENDING || arm_late) begin
          stop = 1'b1;
          ok   = 1'b0;
        end else begin
          mode_d    = esu_pkg::MODE_ARMED;
          hb_time_d = item_i.now_ms;
        end
      end
      esu_pkg::ACT_THROTTLE: begin
        if (!armed_or_run || item_i.pulse_us < cfg_i.safe_pulse_us ||
            item_i.pulse_us > cfg_i.max_pulse_us) begin
          ok = 1'b0;
        end else begin
          target_d  = item_i.pulse_us;
          hb_time_d = item_i.now_ms;
          if (item_i.pulse_us > cfg_i.safe_pulse_us) begin
            if (!running) run_time_d = item_i.now_ms;
            mode_d = esu_pkg::MODE_RUNNING;
          end else begin
            mode_d = esu_pkg::MODE_ARMED;
          end
        end
      end
      esu_pkg::ACT_KEEPALIVE: begin
        if (armed_or_run) hb_time_d = item_i.now_ms;
      end
      esu_pkg::ACT_CLEAR: begin
        if (mode_q == esu_pkg::MODE_FAULT) stop = 1'b1;
      end
      esu_pkg::ACT_TICK: begin
        // Checks in priority order, then the ramp
        if (mode_q == esu_pkg::MODE_PENDING && arm_late) begin
          stop = 1'b1;
        end else if (armed_or_run) begin
          if (hb_late) begin
            trip = 1'b1; trip_code = esu_pkg::FAULT_HEARTBEAT;
          end else if (over_rpm) begin
            trip = 1'b1; trip_code = esu_pkg::FAULT_OVERSPEED;
          end else if (hall_check && item_i.hall_last_us == '0 && start_late) begin
            trip = 1'b1; trip_code = esu_pkg::FAULT_NOHALL;
          end else if (hall_check && item_i.hall_last_us != '0 && hall_late) begin
            trip = 1'b1; trip_code = esu_pkg::FAULT_HALLLOST;
          end else if (!ramp_wait) begin
            ramp_time_d = item_i.now_ms;
            output_d    = ramp_val;
            written     = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Stop: idle pulse, fault cleared, mode from enable
    if (stop) begin
      target_d = cfg_i.safe_pulse_us;
      output_d = cfg_i.safe_pulse_us;
      fault_d  = esu_pkg::FAULT_NONE;
      mode_d   = cfg_i.active_enable ? esu_pkg::MODE_DISARMED : esu_pkg::MODE_LOCKED;
      written  = 1'b1;
    end
    if (pend) mode_d = esu_pkg::MODE_PENDING;
    // Trip: idle pulse and latch the fault
    if (trip) begin
      target_d = cfg_i.safe_pulse_us;
      output_d = cfg_i.safe_pulse_us;
      fault_d  = trip_code;
      mode_d   = esu_pkg::MODE_FAULT;
      written  = 1'b1;
    end
  end

  // Result of this item, from the post-command state
  always_comb begin
    res_o.accepted           = ok;
    res_o.mode_now           = mode_d;
    res_o.requested_pulse_us = target_d;
    res_o.actual_pulse_us    = output_d;
    res_o.fault_code_out     = fault_d;
    res_o.active_allowed     = cfg_i.active_enable && (mode_d != esu_pkg::MODE_FAULT);
    res_o.pulse_written      = written;
  end

  // State registers, updated as the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= esu_pkg::MODE_LOCKED;
      fault_q     <= esu_pkg::FAULT_NONE;
      target_q    <= esu_pkg::PULSE_RST;
      output_q    <= esu_pkg::PULSE_RST;
      arm_time_q  <= '0;
      hb_time_q   <= '0;
      run_time_q  <= '0;
      ramp_time_q <= '0;
    end else if (advance_i) begin
      mode_q      <= mode_d;
      fault_q     <= fault_d;
      target_q    <= target_d;
      output_q    <= output_d;
      arm_time_q  <= arm_time_d;
      hb_time_q   <= hb_time_d;
      run_time_q  <= run_time_d;
      ramp_time_q <= ramp_time_d;
    end
  end

endmodule

// ===== design/esu_duty.sv =====
// ----------------------------------------------------------------------------
// esu_duty
// Two-stage duty count: reciprocal estimate, then correction and saturation.
// ----------------------------------------------------------------------------
module esu_duty (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  esu_pkg::step_res_t  in_res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output esu_pkg::out_item_t  out_item_o
);

  localparam int unsigned PW  = esu_pkg::PULSE_W;
  localparam int unsigned QW  = esu_pkg::DUTY_QW;
  localparam int unsigned RW  = esu_pkg::DUTY_RECIP_W;
  localparam int unsigned NW  = esu_pkg::DUTY_NUM_W;
  localparam int unsigned DB  = esu_pkg::DUTY_BITS;
  localparam int unsigned SH  = esu_pkg::RECIP_SHIFT;

  logic               a_valid_q, b_valid_q;
  logic               a_ready, b_ready;
  esu_pkg::step_res_t a_res_q;
  logic [QW-1:0]      a_q_est_q;
  esu_pkg::out_item_t b_item_q, b_item_d;

  logic [PW+RW-1:0]   prod;
  logic [QW-1:0]      q_est;
  logic [NW-1:0]      num, q_mul, rem;
  logic [QW-1:0]      q_fix;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Stage A: quotient estimate, floor or one below
  always_comb begin
    prod  = (PW+RW)'(in_res_i.actual_pulse_us) * (PW+RW)'(esu_pkg::DUTY_RECIP[RW-1:0]);
    q_est = prod[SH +: QW];
  end

  // Stage B: remainder check and saturation
  always_comb begin
    num   = NW'({a_res_q.actual_pulse_us, {DB{1'b0}}}) - NW'(a_res_q.actual_pulse_us);
    q_mul = NW'(a_q_est_q) * NW'(esu_pkg::PWM_PERIOD_US);
    rem   = num - q_mul;
    q_fix = (rem >= NW'(esu_pkg::PWM_PERIOD_US)) ? (a_q_est_q + QW'(1)) : a_q_est_q;

    b_item_d.accepted           = a_res_q.accepted;
    b_item_d.mode_now           = a_res_q.mode_now;
    b_item_d.requested_pulse_us = a_res_q.requested_pulse_us;
    b_item_d.actual_pulse_us    = a_res_q.actual_pulse_us;
    b_item_d.fault_code_out     = a_res_q.fault_code_out;
    b_item_d.pwm_duty           = (32'(q_fix) > 32'hFFFF) ? 16'hFFFF : 16'(q_fix);
    b_item_d.active_allowed     = a_res_q.active_allowed;
    b_item_d.pulse_written      = a_res_q.pulse_written;
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_res_q   <= in_res_i;
      a_q_est_q <= q_est;
    end
    if (b_ready && a_valid_q) b_item_q <= b_item_d;
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

endmodule

// ===== design/esc_arming_safety_supervisor_unit.sv =====
// ----------------------------------------------------------------------------
// esc_arming_safety_supervisor_unit
// ESC arming safety supervisor: one command or tick in, one status item out.
// ----------------------------------------------------------------------------
// Order: an item passes the input register, state update, duty estimate and
//   duty correction before its result is valid.
// Throughput: one item per cycle while the output is not stalled.
// Reset: asynchronous, active low; mode locked, pulses 1000 us, all
//   timestamps and the fault code cleared, registers at their defaults.
module esc_arming_safety_supervisor_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  esu_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output esu_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic [esu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [esu_pkg::CFG_W-1:0]      cfg_data_i
);

  esu_pkg::cfg_t      cfg;
  logic               in_valid_q;
  esu_pkg::in_item_t  in_q;
  logic               s1_valid_q, s1_ready, duty_ready, advance;
  esu_pkg::step_res_t step_res, s1_q;

  esu_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign s1_ready   = !s1_valid_q || duty_ready;
  assign in_ready_o = !in_valid_q || s1_ready;
  assign advance    = in_valid_q && s1_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (s1_ready)   s1_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_item_i;
    if (advance) s1_q <= step_res;
  end

  esu_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (in_q),
    .advance_i (advance),
    .res_o     (step_res)
  );

  esu_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (duty_ready),
    .in_res_i    (s1_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== design/esu_checker.sv =====
// ----------------------------------------------------------------------------
// esu_checker
// Port-level checks on the supervisor's result stream.
// ----------------------------------------------------------------------------
module esu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input esu_pkg::out_item_t out_item_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Fault code set exactly in fault mode
  a_fault_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.fault_code_out != esu_pkg::FAULT_NONE) ==
                     (out_item_o.mode_now == esu_pkg::MODE_FAULT)))
    else $error("fault code and mode disagree");

  // No active control in fault mode
  a_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.active_allowed |->
      out_item_o.mode_now != esu_pkg::MODE_FAULT)
    else $error("active allowed in fault mode");

  // Outside armed and running, the pulse is not ramping
  a_no_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.mode_now != esu_pkg::MODE_ARMED &&
    out_item_o.mode_now != esu_pkg::MODE_RUNNING |->
      out_item_o.requested_pulse_us == out_item_o.actual_pulse_us)
    else $error("pulse mismatch while not armed");

endmodule

bind esc_arming_safety_supervisor_unit esu_checker u_esu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
